FILE: design/tncp_pkg.sv
// ----------------------------------------------------------------------------
// tncp_pkg
// Shared types and constants for the telnet command parser: telnet codes,
// parser states, register indexes and the action passed from front to back.
// ----------------------------------------------------------------------------
package tncp_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t TN_SE   = 8'd240;
  localparam byte_t TN_SB   = 8'd250;
  localparam byte_t TN_WILL = 8'd251;
  localparam byte_t TN_WONT = 8'd252;
  localparam byte_t TN_DO   = 8'd253;
  localparam byte_t TN_DONT = 8'd254;
  localparam byte_t TN_IAC  = 8'd255;

  localparam byte_t RST_LOCAL_EN = 8'd3;
  localparam byte_t RST_REMOTE_A = 8'd1;
  localparam byte_t RST_REMOTE_B = 8'd3;

  typedef enum logic [1:0] {
    CFG_LOCAL_EN = 2'd0,
    CFG_REMOTE_A = 2'd1,
    CFG_REMOTE_B = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PS_DATA   = 3'd0,
    PS_IAC    = 3'd1,
    PS_WILL   = 3'd2,
    PS_WONT   = 3'd3,
    PS_DO     = 3'd4,
    PS_DONT   = 3'd5,
    PS_SB     = 3'd6,
    PS_SB_IAC = 3'd7
  } parse_state_t;

  typedef enum logic [1:0] {
    STEP_IAC  = 2'd0,
    STEP_VERB = 2'd1,
    STEP_OPT  = 2'd2
  } reply_step_t;

  typedef struct packed {
    logic  is_reply;
    byte_t verb;
    byte_t value;
  } action_t;

endpackage

FILE: design/tncp_front.sv
// ----------------------------------------------------------------------------
// tncp_front
// Accepts received bytes, runs the telnet parser and pushes one action for
// each byte that yields output: a data byte or a negotiation reply.
// ----------------------------------------------------------------------------
module tncp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tncp_pkg::byte_t   in_rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  tncp_pkg::byte_t   cfg_data,
  output logic              push_valid,
  output tncp_pkg::action_t push_action,
  input  logic              q_full
);
  import tncp_pkg::*;

  parse_state_t state_r, state_nxt;
  byte_t        local_en_r, remote_a_r, remote_b_r;
  logic         in_fire;
  logic         emit;

  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_en_r <= RST_LOCAL_EN;
      remote_a_r <= RST_REMOTE_A;
      remote_b_r <= RST_REMOTE_B;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCAL_EN: local_en_r <= cfg_data;
        CFG_REMOTE_A: remote_a_r <= cfg_data;
        CFG_REMOTE_B: remote_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_DATA;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt            = state_r;
    emit                 = 1'b0;
    push_action.is_reply = 1'b1;
    push_action.verb     = TN_DONT;
    push_action.value    = in_rx_byte;
    unique case (state_r)
      PS_DATA: begin
        if (in_rx_byte == TN_IAC) begin
          state_nxt = PS_IAC;
        end else begin
          emit                 = 1'b1;
          push_action.is_reply = 1'b0;
        end
      end
      PS_IAC: begin
        state_nxt = PS_DATA;
        unique case (in_rx_byte)
          TN_IAC: begin
            emit                 = 1'b1;
            push_action.is_reply = 1'b0;
          end
          TN_WILL: state_nxt = PS_WILL;
          TN_WONT: state_nxt = PS_WONT;
          TN_DO:   state_nxt = PS_DO;
          TN_DONT: state_nxt = PS_DONT;
          TN_SB:   state_nxt = PS_SB;
          default: state_nxt = PS_DATA;
        endcase
      end
      PS_WILL: begin
        emit      = 1'b1;
        state_nxt = PS_DATA;
        if (in_rx_byte == remote_a_r || in_rx_byte == remote_b_r) begin
          push_action.verb = TN_DO;
        end
      end
      PS_WONT: begin
        emit      = 1'b1;
        state_nxt = PS_DATA;
      end
      PS_DO: begin
        emit             = 1'b1;
        state_nxt        = PS_DATA;
        push_action.verb = (in_rx_byte == local_en_r) ? TN_WILL : TN_WONT;
      end
      PS_DONT: begin
        emit             = 1'b1;
        state_nxt        = PS_DATA;
        push_action.verb = TN_WONT;
      end
      PS_SB: begin
        if (in_rx_byte == TN_IAC) begin
          state_nxt = PS_SB_IAC;
        end
      end
      PS_SB_IAC: begin
        state_nxt = (in_rx_byte == TN_SE) ? PS_DATA : PS_SB;
      end
      default: state_nxt = PS_DATA;
    endcase
  end

  assign push_valid = in_fire && emit;

  a_opt_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (state_r == PS_WILL || state_r == PS_WONT || state_r == PS_DO ||
                state_r == PS_DONT) |=> state_r == PS_DATA)
    else $error("parser did not return to data after option byte");

endmodule

FILE: design/tncp_queue.sv
// ----------------------------------------------------------------------------
// tncp_queue
// Short action queue between parser and reply sequencer.
// ----------------------------------------------------------------------------
module tncp_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  tncp_pkg::action_t push_action,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tncp_pkg::action_t pop_action
);
  import tncp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  action_t           mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_action = mem[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_action;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push_valid)
    else $error("action pushed into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count out of range");

endmodule

FILE: design/tncp_back.sv
// ----------------------------------------------------------------------------
// tncp_back
// Pops actions and drives the result register: one byte for data, three
// bytes (IAC, verb, option) for a negotiation reply.
// ----------------------------------------------------------------------------
module tncp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  tncp_pkg::action_t pop_action,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_channel,
  output tncp_pkg::byte_t   out_byte,
  output logic              out_last
);
  import tncp_pkg::*;

  action_t     act_r, act_nxt;
  reply_step_t step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic        out_fire;

  assign out_fire    = valid_r && out_ready;
  assign out_valid   = valid_r;
  assign out_channel = act_r.is_reply;
  assign out_last    = !act_r.is_reply || (step_r == STEP_OPT);
  assign pop_ready   = !valid_r || (out_fire && out_last);

  always_comb begin
    if (!act_r.is_reply) begin
      out_byte = act_r.value;
    end else begin
      unique case (step_r)
        STEP_IAC:  out_byte = TN_IAC;
        STEP_VERB: out_byte = act_r.verb;
        STEP_OPT:  out_byte = act_r.value;
        default:   out_byte = act_r.value;
      endcase
    end
  end

  always_comb begin
    act_nxt   = act_r;
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (pop_ready) begin
      valid_nxt = pop_valid;
      act_nxt   = pop_action;
      step_nxt  = STEP_IAC;
    end else if (out_fire) begin
      step_nxt = (step_r == STEP_IAC) ? STEP_VERB : STEP_OPT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= STEP_IAC;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
  end

  a_reply_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last |=> valid_r && act_r.is_reply && step_r != STEP_IAC)
    else $error("reply cut short");

endmodule

FILE: design/telnet_command_parser_unit.sv
// ----------------------------------------------------------------------------
// telnet_command_parser_unit
// Telnet receive parser: passes data bytes, unescapes doubled IAC, drops
// commands and subnegotiations, answers option verbs with 3-byte replies.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_rx_byte[7:0]
//   out_     out  out_valid/out_ready  out_channel, out_byte[7:0], out_last
//   cfg_     in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[7:0]
//
// A byte is taken every cycle while the action queue has room; a result
// is registered in the action queue, then in the result register. Output
// runs one byte per cycle while out_ready is high, from the result register.
// Reset is synchronous; the parser returns to the data state and registers
// take their defaults. out_ready low fills the queue, then drops in_ready.
// ----------------------------------------------------------------------------
module telnet_command_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tncp_pkg::byte_t in_rx_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_channel,
  output tncp_pkg::byte_t out_byte,
  output logic            out_last,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  tncp_pkg::byte_t cfg_data
);
  import tncp_pkg::*;

  logic    push_valid, q_full, pop_valid, pop_ready;
  action_t push_action, pop_action;

  tncp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push_valid  (push_valid),
    .push_action (push_action),
    .q_full      (q_full)
  );

  tncp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_valid  (push_valid),
    .push_action (push_action),
    .full        (q_full),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_action  (pop_action)
  );

  tncp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_action  (pop_action),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

endmodule
